/* sv/sbrq_pkg.sv */
`timescale 1ns / 1ps
package sbrq_pkg;
  localparam int MaxRefillsDefault = 16;
  localparam int DataW = 64;
  localparam int CntW = 5;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_APPLY   = 2'd1,
    KIND_CHARGE  = 2'd2,
    KIND_UNBLOCK = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_PERIOD      = 3'd0,
    REG_BUDGET      = 3'd1,
    REG_MAX_REFILLS = 3'd2,
    REG_MIN_BUDGET  = 3'd3,
    REG_MAX_RELEASE = 3'd4,
    REG_READY_SLACK = 3'd5
  } reg_idx_t;
endpackage

/* sv/sporadic_budget_refill_queue_top.sv */
`timescale 1ns / 1ps
// A start or apply writes slot 0; round robin adds an empty tail refill, and an apply
// short of the budget adds the rest one period on. Charge: refills charged in full (at
// most 4*MAX_REFILLS) move on in place or recycle to the tail, then a partial charge
// and fold steps. Unblock: a ready head moves to now and merges refills after it. One
// request at a time, busy drops with the strobe; the receiver cannot stall. Reset
// returns indices, sequencer and config to defaults; slots are undefined until start.
module sporadic_budget_refill_queue_top
  import sbrq_pkg::*;
#(
  parameter int MAX_REFILLS = MaxRefillsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [DataW-1:0]  now_time,
  input  logic [DataW-1:0]  usage,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [DataW-1:0]  cfg_data,
  output logic              done,
  output logic [DataW-1:0]  head_amount,
  output logic [DataW-1:0]  head_time,
  output logic [CntW-1:0]   refill_count,
  output logic              reprogram
);
  localparam int IdxW = (MAX_REFILLS > 1) ? $clog2(MAX_REFILLS) : 1;
  localparam int SW = $clog2(MAX_REFILLS + 1);
  localparam int ChargeLimit = 4 * MAX_REFILLS;
  localparam int NW = $clog2(ChargeLimit + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CUT, S_RR_TAIL, S_AP_TAIL,
    S_CH_TEST, S_SCHED_RD, S_SCHED, S_HEAD_RD, S_HEAD_LD,
    S_FOLD_TEST, S_FOLD_UPD, S_UB_TEST, S_UB_MERGE, S_OUT
  } state_t;

  state_t state;
  kind_t k;
  logic [DataW-1:0] period, budget, floor_amount, max_release, ready_slack;
  logic [CntW-1:0] slot_limit;

  logic [DataW-1:0] mem_t [MAX_REFILLS];
  logic [DataW-1:0] mem_a [MAX_REFILLS];
  logic [IdxW-1:0] rd_addr;
  logic [DataW-1:0] rd_t, rd_a;

  logic [IdxW-1:0] head, tail;
  logic [DataW-1:0] now, use_left;
  logic [DataW-1:0] ht, ha;   // head refill copy, kept in step with its slot
  logic [DataW-1:0] st, sa;   // refill being recycled
  logic [NW-1:0] n_chg;
  logic part_phase;
  logic rprg;

  logic [SW-1:0] slots;
  logic [SW:0] cnt;
  logic [DataW:0] lim_sum;
  logic [DataW-1:0] lim;
  logic [IdxW-1:0] head_nx, head_nx2, tail_nx;
  logic need_cut;
  logic [DataW-1:0] ap_time, ap_amt;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] i,
                                          input logic [SW-1:0] m);
    logic [SW:0] s;
    s = (SW+1)'(i) + (SW+1)'(1);
    nxt = (s >= (SW+1)'(m)) ? '0 : IdxW'(s);
  endfunction

  // clamped slot count
  always_comb begin
    if (slot_limit < CntW'(2)) slots = SW'(2);
    else if (32'(slot_limit) > MAX_REFILLS) slots = SW'(MAX_REFILLS);
    else slots = SW'(slot_limit);
  end

  always_comb begin
    if (tail >= head) cnt = (SW+1)'(tail) - (SW+1)'(head) + (SW+1)'(1);
    else cnt = (SW+1)'(slots) - (SW+1)'(head) + (SW+1)'(tail) + (SW+1)'(1);
  end

  // ready limit saturates
  assign lim_sum = {1'b0, now} + {1'b0, ready_slack};
  assign lim = lim_sum[DataW] ? '1 : lim_sum[DataW-1:0];

  assign head_nx = nxt(head, slots);
  assign head_nx2 = nxt(head_nx, slots);
  assign tail_nx = nxt(tail, slots);
  assign need_cut = (SW'(head) >= slots) || (SW'(tail) >= slots);
  assign ap_time = (rd_t <= lim) ? now : rd_t;
  assign ap_amt = (rd_a >= budget) ? budget : rd_a;

  always_comb begin
    unique case (state)
      S_SCHED_RD: rd_addr = tail;
      S_FOLD_TEST, S_UB_TEST: rd_addr = head_nx;
      S_UB_MERGE: rd_addr = head_nx2;
      default: rd_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_t <= mem_t[rd_addr];
    rd_a <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0; done <= 1'b0; reprogram <= 1'b0; rprg <= 1'b0;
      head <= '0; tail <= '0;
      period <= '0; budget <= '0; floor_amount <= '0; ready_slack <= '0;
      max_release <= '1; slot_limit <= CntW'(2);
      head_amount <= '0; head_time <= '0; refill_count <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_PERIOD:      period <= cfg_data;
          REG_BUDGET:      budget <= cfg_data;
          REG_MAX_REFILLS: slot_limit <= cfg_data[CntW-1:0];
          REG_MIN_BUDGET:  floor_amount <= cfg_data;
          REG_MAX_RELEASE: max_release <= cfg_data;
          REG_READY_SLACK: ready_slack <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: if (start && !busy) begin
          busy <= 1'b1; k <= kind_t'(kind); now <= now_time; use_left <= usage;
          rprg <= 1'b0; n_chg <= '0; part_phase <= 1'b0;
          state <= S_CUT;
        end
        // rd holds the head slot here
        S_CUT: begin
          unique case (k)
            KIND_START: begin
              mem_t[IdxW'(0)] <= now; mem_a[IdxW'(0)] <= budget;
              head <= '0; tail <= '0; ht <= now; ha <= budget;
              state <= (period == '0) ? S_RR_TAIL : S_OUT;
            end
            KIND_APPLY: begin
              mem_t[IdxW'(0)] <= ap_time; mem_a[IdxW'(0)] <= ap_amt;
              head <= '0; tail <= '0; ht <= ap_time; ha <= ap_amt;
              if (rd_a >= budget) state <= (period == '0) ? S_RR_TAIL : S_OUT;
              else state <= S_AP_TAIL;
            end
            default: begin
              if (need_cut) begin
                mem_t[IdxW'(0)] <= rd_t; mem_a[IdxW'(0)] <= rd_a;
                head <= '0; tail <= '0;
              end
              ht <= rd_t; ha <= rd_a;
              if (period == '0) state <= S_OUT;
              else if (k == KIND_CHARGE) state <= S_CH_TEST;
              else state <= S_UB_TEST;
            end
          endcase
        end
        S_RR_TAIL: begin
          mem_t[tail_nx] <= ht; mem_a[tail_nx] <= '0; tail <= tail_nx;
          state <= S_OUT;
        end
        S_AP_TAIL: begin
          mem_t[tail_nx] <= ht + period; mem_a[tail_nx] <= budget - ha; tail <= tail_nx;
          state <= S_OUT;
        end
        S_CH_TEST: begin
          if (ha <= use_left && ht < max_release && n_chg < NW'(ChargeLimit)) begin
            n_chg <= n_chg + NW'(1);
            use_left <= use_left - ha;
            if (head == tail) begin
              mem_t[head] <= ht + period;
              ht <= ht + period;
            end else begin
              st <= ht + period; sa <= ha; head <= head_nx;
              part_phase <= 1'b0;
              state <= S_SCHED_RD;
            end
          end else if (use_left != '0 && ha > use_left && ht < max_release) begin
            // partial charge of the head
            mem_t[head] <= ht + use_left; mem_a[head] <= ha - use_left;
            ht <= ht + use_left; ha <= ha - use_left;
            st <= ht + period; sa <= use_left; part_phase <= 1'b1;
            state <= S_SCHED_RD;
          end else begin
            state <= S_FOLD_TEST;
          end
        end
        S_SCHED_RD: state <= S_SCHED;
        // rd holds the tail refill
        S_SCHED: begin
          if (rd_t + rd_a >= st) begin
            mem_a[tail] <= rd_a + sa;
          end else if (cnt < (SW+1)'(slots)) begin
            mem_t[tail_nx] <= st; mem_a[tail_nx] <= sa; tail <= tail_nx;
          end else begin
            mem_t[tail] <= st - rd_a; mem_a[tail] <= rd_a + sa;
          end
          state <= S_HEAD_RD;
        end
        S_HEAD_RD: state <= S_HEAD_LD;
        S_HEAD_LD: begin
          ht <= rd_t; ha <= rd_a;
          state <= part_phase ? S_FOLD_TEST : S_CH_TEST;
        end
        S_FOLD_TEST: begin
          if (ha < floor_amount && head != tail) begin
            head <= head_nx;
            state <= S_FOLD_UPD;
          end else begin
            state <= S_OUT;
          end
        end
        // rd holds the new head; ha still the folded amount
        S_FOLD_UPD: begin
          mem_t[head] <= rd_t - ha; mem_a[head] <= rd_a + ha;
          ht <= rd_t - ha; ha <= rd_a + ha;
          state <= S_FOLD_TEST;
        end
        S_UB_TEST: begin
          if (ht <= lim) begin
            rprg <= 1'b1;
            mem_t[head] <= now; ht <= now;
            state <= S_UB_MERGE;
          end else begin
            state <= S_OUT;
          end
        end
        // rd holds the refill after head
        S_UB_MERGE: begin
          if (head != tail && rd_t <= ht + ha) begin
            mem_t[head_nx] <= ht; mem_a[head_nx] <= rd_a + ha;
            ha <= rd_a + ha; head <= head_nx;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          head_time <= ht; head_amount <= ha;
          refill_count <= CntW'(cnt);
          reprogram <= rprg;
          done <= 1'b1; busy <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request not taken");
  assert property (@(posedge clk) disable iff (rst) done |-> refill_count != '0)
    else $error("empty queue reported");
endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top
  import sbrq_pkg::*;
();

  localparam int SLOTS_MAX = 16;
  localparam int CHARGE_CAP = 4 * SLOTS_MAX;
  localparam longint unsigned CYCLE_LIMIT = 64'd3000000;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = KIND_START;
  logic [DataW-1:0] now_time = '0;
  logic [DataW-1:0] usage = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_PERIOD;
  logic [DataW-1:0] cfg_data = '0;
  logic done;
  logic [DataW-1:0] head_amount;
  logic [DataW-1:0] head_time;
  logic [CntW-1:0] refill_count;
  logic reprogram;

  sporadic_budget_refill_queue_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .now_time(now_time), .usage(usage), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .head_amount(head_amount),
    .head_time(head_time), .refill_count(refill_count), .reprogram(reprogram)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] now_time;
    logic [63:0] usage;
  } request_t;

  typedef struct packed {
    logic [63:0] amount;
    logic [63:0] rtime;
    logic [4:0]  count;
    logic        reprog;
  } head_view_t;

  // predictor state
  logic [63:0] q_time [SLOTS_MAX];
  logic [63:0] q_amount [SLOTS_MAX];
  int unsigned q_head, q_tail;
  logic [63:0] p_period, p_budget, p_floor_amount, p_max_release, p_slack;
  logic [4:0] p_slot_limit;

  request_t   pending_requests [$];
  head_view_t expected_heads [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned requests_sent = 0;
  int unsigned send_idle_pct = 0;
  longint unsigned cycles = 0;
  int unsigned reprogram_hits = 0;

  function automatic int unsigned slot_count();
    int unsigned m;
    m = p_slot_limit;
    if (m < 2) m = 2;
    if (m > SLOTS_MAX) m = SLOTS_MAX;
    return m;
  endfunction

  function automatic int unsigned step_slot(int unsigned i);
    return (i + 1 >= slot_count()) ? 0 : i + 1;
  endfunction

  function automatic int unsigned queue_len();
    if (q_tail >= q_head) return q_tail - q_head + 1;
    return slot_count() - q_head + q_tail + 1;
  endfunction

  function automatic void collapse_to_head();
    q_time[0] = q_time[q_head];
    q_amount[0] = q_amount[q_head];
    q_head = 0;
    q_tail = 0;
  endfunction

  function automatic bit head_ready(logic [63:0] now);
    logic [64:0] lim;
    lim = {1'b0, now} + {1'b0, p_slack};
    if (lim[64]) lim = {1'b0, ALL_ONES};
    return q_time[q_head] <= lim[63:0];
  endfunction

  function automatic void push_refill(logic [63:0] t, logic [63:0] a);
    q_tail = step_slot(q_tail);
    q_time[q_tail] = t;
    q_amount[q_tail] = a;
  endfunction

  function automatic void push_empty_if_rr();
    if (p_period == 0) push_refill(q_time[q_head], 64'd0);
  endfunction

  function automatic void recycle_used(logic [63:0] t, logic [63:0] a);
    int unsigned k;
    logic [63:0] tail_end;
    k = q_tail;
    tail_end = q_time[k] + q_amount[k];
    if (tail_end >= t) begin
      q_amount[k] = q_amount[k] + a;
    end else if (queue_len() < slot_count()) begin
      push_refill(t, a);
    end else begin
      q_time[k] = t - q_amount[k];
      q_amount[k] = q_amount[k] + a;
    end
  endfunction

  function automatic void charge_usage(logic [63:0] used);
    int unsigned n;
    logic [63:0] t, a;
    n = 0;
    if (p_period == 0) return;
    while (q_amount[q_head] <= used && q_time[q_head] < p_max_release && n < CHARGE_CAP) begin
      n++;
      used = used - q_amount[q_head];
      if (q_head == q_tail) begin
        q_time[q_head] = q_time[q_head] + p_period;
      end else begin
        t = q_time[q_head];
        a = q_amount[q_head];
        q_head = step_slot(q_head);
        recycle_used(t + p_period, a);
      end
    end
    if (q_amount[q_head] <= used) used = 0;
    if (used > 0 && q_time[q_head] < p_max_release) begin
      t = q_time[q_head] + p_period;
      q_amount[q_head] = q_amount[q_head] - used;
      q_time[q_head] = q_time[q_head] + used;
      recycle_used(t, used);
    end
    // fold small heads forward, never past the last refill
    while (q_amount[q_head] < p_floor_amount && q_head != q_tail) begin
      a = q_amount[q_head];
      q_head = step_slot(q_head);
      q_amount[q_head] = q_amount[q_head] + a;
      q_time[q_head] = q_time[q_head] - a;
    end
  endfunction

  function automatic bit unblock_head(logic [63:0] now);
    logic [63:0] t, a;
    if (p_period == 0 || !head_ready(now)) return 1'b0;
    q_time[q_head] = now;
    while (q_head != q_tail &&
           q_time[step_slot(q_head)] <= q_time[q_head] + q_amount[q_head]) begin
      t = q_time[q_head];
      a = q_amount[q_head];
      q_head = step_slot(q_head);
      q_time[q_head] = t;
      q_amount[q_head] = q_amount[q_head] + a;
    end
    return 1'b1;
  endfunction

  function automatic head_view_t predict_head(request_t r);
    head_view_t v;
    bit rp;
    rp = 1'b0;
    if (q_head >= slot_count() || q_tail >= slot_count()) collapse_to_head();
    case (kind_t'(r.kind))
      KIND_START: begin
        q_head = 0;
        q_tail = 0;
        q_amount[0] = p_budget;
        q_time[0] = r.now_time;
        push_empty_if_rr();
      end
      KIND_APPLY: begin
        collapse_to_head();
        if (head_ready(r.now_time)) q_time[0] = r.now_time;
        if (q_amount[0] >= p_budget) begin
          q_amount[0] = p_budget;
          push_empty_if_rr();
        end else begin
          push_refill(q_time[0] + p_period, p_budget - q_amount[0]);
        end
      end
      KIND_CHARGE: charge_usage(r.usage);
      default: rp = unblock_head(r.now_time);
    endcase
    v.amount = q_amount[q_head];
    v.rtime = q_time[q_head];
    v.count = 5'(queue_len());
    v.reprog = rp;
    return v;
  endfunction

  function automatic void note_config(reg_idx_t idx, logic [63:0] val);
    case (idx)
      REG_PERIOD:      p_period = val;
      REG_BUDGET:      p_budget = val;
      REG_MAX_REFILLS: p_slot_limit = val[4:0];
      REG_MIN_BUDGET:  p_floor_amount = val;
      REG_MAX_RELEASE: p_max_release = val;
      REG_READY_SLACK: p_slack = val;
      default: ;
    endcase
  endfunction

  // driver: one request in flight; prediction happens on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_heads.push_back(predict_head({kind, now_time, usage}));
        requests_sent++;
      end
      if (start && busy) begin
        // hold the current request
      end else if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        kind <= pending_requests[0].kind;
        now_time <= pending_requests[0].now_time;
        usage <= pending_requests[0].usage;
        void'(pending_requests.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    head_view_t want;
    if (!rst && done) begin
      results_seen++;
      if (reprogram) reprogram_hits++;
      if (expected_heads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        want = expected_heads.pop_front();
        if (head_amount !== want.amount || head_time !== want.rtime ||
            refill_count !== want.count || reprogram !== want.reprog) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: exp amt=%h time=%h cnt=%0d rp=%b got amt=%h time=%h cnt=%0d rp=%b",
                     results_seen, want.amount, want.rtime, want.count, want.reprog,
                     head_amount, head_time, refill_count, reprogram);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // moving base so refills interact
  logic [63:0] base_now;

  task automatic wait_drained();
    while (pending_requests.size() > 0 || start || busy || expected_heads.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    note_config(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_request(kind_t k, logic [63:0] t, logic [63:0] u);
    request_t r;
    r.kind = k;
    r.now_time = t;
    r.usage = u;
    pending_requests.push_back(r);
  endtask

  task automatic random_config(int unsigned flavor);
    logic [63:0] per, bud;
    per = (flavor == 0) ? 64'd0 : 64'($urandom_range(40, 400));
    bud = 64'($urandom_range(1, 200));
    write_reg(REG_PERIOD, per);
    write_reg(REG_BUDGET, bud);
    write_reg(REG_MAX_REFILLS, 64'($urandom_range(2, 16)));
    write_reg(REG_MIN_BUDGET, ($urandom_range(3) == 0) ? 64'd0 : 64'($urandom_range(30)));
    write_reg(REG_MAX_RELEASE, ($urandom_range(2) == 0) ? ALL_ONES :
              64'($urandom_range(2000, 200000)));
    write_reg(REG_READY_SLACK, 64'($urandom_range(20)));
  endtask

  task automatic random_block(int unsigned n);
    int unsigned r;
    queue_request(KIND_START, base_now, 64'd0);
    for (int unsigned i = 0; i < n; i++) begin
      base_now = base_now + 64'($urandom_range(60));
      r = $urandom_range(99);
      if (r < 4) queue_request(KIND_START, base_now, 64'd0);
      else if (r < 12) queue_request(KIND_APPLY, base_now, 64'd0);
      else if (r < 62)
        queue_request(KIND_CHARGE, base_now, ($urandom_range(30) == 0) ? rand64() :
                      64'($urandom_range(250)));
      else queue_request(KIND_UNBLOCK, ($urandom_range(25) == 0) ? rand64() : base_now,
                         64'd0);
    end
  endtask

  initial begin
    p_period = '0;
    p_budget = '0;
    p_slot_limit = 5'd2;
    p_floor_amount = '0;
    p_max_release = ALL_ONES;
    p_slack = '0;
    q_head = 0;
    q_tail = 0;
    base_now = 64'd1000;
    for (int i = 0; i < SLOTS_MAX; i++) begin
      q_time[i] = '0;
      q_amount[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: round robin first, then extreme values
    queue_request(KIND_START, 64'd0, 64'd0);
    queue_request(KIND_CHARGE, 64'd5, ALL_ONES);
    queue_request(KIND_UNBLOCK, ALL_ONES, 64'd0);
    queue_request(KIND_APPLY, 64'd7, 64'd0);
    wait_drained();
    write_reg(REG_PERIOD, 64'd100);
    write_reg(REG_BUDGET, 64'd40);
    write_reg(REG_MAX_REFILLS, 64'd16);
    write_reg(REG_MIN_BUDGET, 64'd5);
    write_reg(REG_MAX_RELEASE, ALL_ONES);
    write_reg(REG_READY_SLACK, ALL_ONES);
    queue_request(KIND_START, 64'd1000, 64'd0);
    queue_request(KIND_CHARGE, 64'd0, 64'd3);
    queue_request(KIND_CHARGE, 64'd0, 64'd1);
    queue_request(KIND_CHARGE, 64'd0, 64'd2);
    queue_request(KIND_CHARGE, 64'd0, ALL_ONES);
    queue_request(KIND_UNBLOCK, ALL_ONES - 64'd3, 64'd0);
    queue_request(KIND_UNBLOCK, 64'd0, 64'd0);
    queue_request(KIND_APPLY, 64'd2000, 64'd0);
    wait_drained();
    // over-range slot limit without apply, then a high minimum budget and low release limit
    write_reg(REG_MAX_REFILLS, 64'd31);
    write_reg(REG_MIN_BUDGET, ALL_ONES);
    write_reg(REG_MAX_RELEASE, 64'd1500);
    write_reg(REG_READY_SLACK, 64'd0);
    write_reg(REG_BUDGET, ALL_ONES);
    queue_request(KIND_CHARGE, 64'd0, 64'd20);
    queue_request(KIND_APPLY, 64'd1100, 64'd0);
    queue_request(KIND_START, ALL_ONES, 64'd0);
    queue_request(KIND_CHARGE, 64'd0, 64'd1);
    queue_request(KIND_UNBLOCK, 64'd0, 64'd0);
    wait_drained();
    write_reg(REG_PERIOD, ALL_ONES);
    write_reg(REG_MAX_REFILLS, 64'd0);
    queue_request(KIND_START, 64'h8000_0000_0000_0000, 64'd0);
    queue_request(KIND_CHARGE, 64'd0, 64'h5555_5555_5555_5555);
    queue_request(KIND_UNBLOCK, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0);
    wait_drained();

    // random phases with differing sender idling
    for (int unsigned ph = 0; ph < 26; ph++) begin
      case (ph % 4)
        0: send_idle_pct = 0;
        1: send_idle_pct = 77;
        2: send_idle_pct = 0;
        default: send_idle_pct = 29;
      endcase
      random_config((ph % 5 == 0) ? 0 : 1);
      random_block(48);
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d unblocks reprogrammed, %0d mismatches",
             requests_sent, results_seen, reprogram_hits, mismatches);
    $display("covered round robin, start/apply/charge/unblock, slot shrink and extreme fields");
    if (mismatches == 0 && expected_heads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/sbrq_pkg.sv
sv/sporadic_budget_refill_queue_top.sv
sim/tb_top.sv
